/* src/rsm_pkg.sv */
// Shared types and fixed widths for the ring/stripe moire pixel shader.
// Used by the square-root pipeline and by the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsm_pkg;

	// Squared half-pixel distance, widest at a 1024 px screen.
	localparam int unsigned D4_W = 22;
	// Radicand d4 << 14 so that the root carries 7 fractional bits (8 in whole pixels).
	localparam int unsigned RAD_PAD = 14;
	localparam int unsigned RAD_W = D4_W + RAD_PAD;
	localparam int unsigned ROOT_W = RAD_W / 2;
	localparam int unsigned REM_W = ROOT_W + 2;

	// Two root bits resolved per register stage.
	localparam int unsigned SQRT_STEPS = 2;
	localparam int unsigned SQRT_STAGES = ROOT_W / SQRT_STEPS;

	// Reciprocal of 255 for exact floor division of values below 2^16.
	localparam int unsigned DIV255_S = 24;
	localparam logic [16:0] DIV255_M = 17'd65794;

	typedef logic [7:0] cov8_t;

endpackage

`default_nettype wire

/* src/rsm_isqrt.sv */
// Pipelined integer square root: floor root and remainder of (d4 << 14).
// Depends on rsm_pkg for widths and stage count; data registers only.
`timescale 1ns / 1ps
`default_nettype none

module rsm_isqrt
	import rsm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [D4_W-1:0]   radicand,
	output logic      [ROOT_W-1:0] root,
	output logic      [REM_W-1:0]  rem
);

	logic [RAD_W-1:0]  rad_q  [SQRT_STAGES-1];
	logic [ROOT_W-1:0] root_q [SQRT_STAGES];
	logic [REM_W-1:0]  rem_q  [SQRT_STAGES];

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		logic [RAD_W-1:0]  rad_in;
		logic [ROOT_W-1:0] root_in;
		logic [REM_W-1:0]  rem_in;
		logic [RAD_W-1:0]  rad_nx;
		logic [ROOT_W-1:0] root_nx;
		logic [REM_W-1:0]  rem_nx;

		if (g == 0) begin : g_first
			assign rad_in  = {radicand, {RAD_PAD{1'b0}}};
			assign root_in = '0;
			assign rem_in  = '0;
		end else begin : g_next
			assign rad_in  = rad_q[g-1];
			assign root_in = root_q[g-1];
			assign rem_in  = rem_q[g-1];
		end

		always_comb begin
			logic [REM_W:0] acc;
			logic [REM_W:0] trial;
			rad_nx  = rad_in;
			root_nx = root_in;
			rem_nx  = rem_in;
			acc     = '0;
			trial   = '0;
			for (int s = 0; s < SQRT_STEPS; s++) begin
				// bring down the next two radicand bits, try root*4+1
				acc   = {rem_nx[REM_W-2:0], rad_nx[RAD_W-1 -: 2]};
				trial = (REM_W+1)'({root_nx, 2'b01});
				if (acc >= trial) begin
					rem_nx  = REM_W'(acc - trial);
					root_nx = {root_nx[ROOT_W-2:0], 1'b1};
				end else begin
					rem_nx  = REM_W'(acc);
					root_nx = {root_nx[ROOT_W-2:0], 1'b0};
				end
				rad_nx = {rad_nx[RAD_W-3:0], 2'b00};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_q[g] <= root_nx;
				rem_q[g]  <= rem_nx;
			end
		end

		if (g < SQRT_STAGES - 1) begin : g_rad
			always_ff @(posedge clk) begin
				if (en) begin
					rad_q[g] <= rad_nx;
				end
			end
		end
	end

	assign root = root_q[SQRT_STAGES-1];
	assign rem  = rem_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

/* src/ring_stripe_moire_pixel_shader.sv */
// Top level of the ring/stripe moire pixel shader: pixel in, coverage out.
// Depends on rsm_pkg and rsm_isqrt.
`timescale 1ns / 1ps
`default_nettype none

// One pixel word per clock in and out while the output is not held. The depth
// comes from the square root (9 stages, two root bits each) followed by the
// reciprocal divisions for ring index, ring weight and the final 8-bit mixes.
// The whole pipe advances as one: it moves whenever the output register is
// empty or being taken, so pix_stall simply mirrors a held output word.
// cfg_ready is always high; write stripe_phase only while no pixel is in
// flight.

module ring_stripe_moire_pixel_shader
	import rsm_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 240,
	parameter int RING_COUNT    = 19
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        pix_valid,
	output logic             pix_stall,
	input  wire logic [7:0]  pixel_x,
	input  wire logic [7:0]  pixel_y,
	input  wire logic        end_of_frame,
	output logic             cov_valid,
	input  wire logic        cov_stall,
	output logic [7:0]       fg_coverage,
	output logic             frame_done
);

	localparam int LAST = 22;

	localparam logic [11:0] W12 = 12'(SCREEN_WIDTH);
	localparam logic [11:0] H12 = 12'(SCREEN_HEIGHT);
	localparam logic [35:0] RC36 = 36'(RING_COUNT);
	localparam logic [35:0] W2_36 = 36'(2 * SCREEN_WIDTH);
	localparam logic [35:0] HALF36 = 36'(64'(RING_COUNT) << 16);
	localparam logic [63:0] BIAS_B = ((64'd1 << 16) + 64'(SCREEN_WIDTH) - 64'd1)
		/ 64'(SCREEN_WIDTH);
	localparam logic [35:0] BIAS = 36'(BIAS_B * 64'(SCREEN_WIDTH) * 64'd131072);
	localparam logic [23:0] MW = 24'(((64'd1 << 27) + 64'(SCREEN_WIDTH) - 64'd1)
		/ 64'(SCREEN_WIDTH));
	localparam logic [26:0] RING_U = 27'(64'(SCREEN_WIDTH) << 16);
	localparam logic [23:0] UPX = 24'(64'(RING_COUNT) << 17);
	localparam logic [25:0] MKB = 26'(((64'd1 << 29) + 64'(SCREEN_WIDTH) - 64'd1)
		/ 64'(SCREEN_WIDTH));
	localparam logic [20:0] MRC = 21'(((64'd1 << 21) + 64'(RING_COUNT) - 64'd1)
		/ 64'(RING_COUNT));
	localparam logic [14:0] FULL = 15'(RING_COUNT * 256);
	localparam logic [20:0] RIM0 = 21'(SCREEN_WIDTH * 128 + 128);
	localparam logic [26:0] KB_OFF = 27'(SCREEN_WIDTH * 128);
	localparam logic [27:0] A_OFF = 28'(RING_COUNT * 128);
	localparam logic [14:0] KB_MAX = 15'(RING_COUNT - 1);

	// control
	logic            en;
	logic [LAST:1]   vld_q;
	logic [LAST:1]   eof_q;
	logic [15:0]     phase_q;

	// geometry
	logic signed [11:0] dx_s1, dy_s1;
	logic [19:0]        sqx_s2, sqy_s2;
	logic [35:0]        pu_s2;
	logic [D4_W-1:0]    d4_s3;
	logic [33:0]        ta_s3, tb_s3;

	// stripe path
	logic [40:0] prod_a, prod_b;
	logic [13:0] qa_s4, qb_s4;
	logic [16:0] tah_s4, tbh_s4, tal_s4, tbl_s4;
	logic [9:0]  fha_s5, fhb_s5;
	logic [16:0] tal_s5, tbl_s5;
	logic [3:0]  qd_s5, qd_s6;
	logic [26:0] fa, fb;
	logic [25:0] ca_s6, cb_s6;
	logic [31:0] cov_raw;
	logic [23:0] cov_s7;
	logic [14:0] cn_s8;
	logic [35:0] prod_c;
	cov8_t       c0_s9;
	cov8_t       c0_dly_q [10:18];

	// distance path
	logic [ROOT_W-1:0] sq_root;
	logic [REM_W-1:0]  sq_rem;
	logic [18:0]       dq_s13, dq_s14, dq_s15;
	logic [18:0]       nk8_s14;
	logic signed [20:0] rc_raw;
	logic [8:0]        rc_cl;
	cov8_t             m_s14;
	cov8_t             m_dly_q [15:20];
	logic [44:0]       prod_k;
	logic [14:0]       kb_s15;
	logic [27:0]       a_raw;
	logic [27:0]       a_s16;
	logic              odd_s16, rng_s16, rng_s17;
	logic [14:0]       ac, af;
	logic [14:0]       wn_s17;
	logic [35:0]       prod_w;
	cov8_t             w_s18;
	logic [15:0]       p_s19;
	logic [32:0]       prod_mix;
	cov8_t             mix_s20;
	logic [15:0]       fgp_s21;
	logic [32:0]       prod_fg;
	cov8_t             fg_s22;

	assign en        = !vld_q[LAST] || !cov_stall;
	assign pix_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			phase_q <= '0;
		end else begin
			if (en) vld_q <= {vld_q[LAST-1:1], pix_valid};
			if (cfg_valid) phase_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (en) eof_q <= {eof_q[LAST-1:1], end_of_frame};
	end

	// front: half-pixel offsets, squares, stripe position
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= 12'({3'b000, pixel_x, 1'b1}) - W12;
			dy_s1  <= 12'({3'b000, pixel_y, 1'b1}) - H12;
			sqx_s2 <= 20'(dx_s1 * dx_s1);
			sqy_s2 <= 20'(dy_s1 * dy_s1);
			pu_s2  <= ((36'(dx_s1) * RC36) << 16) + 36'(phase_q) * W2_36;
			d4_s3  <= D4_W'(sqx_s2) + D4_W'(sqy_s2);
			// bias keeps both stripe ends non-negative; it cancels in the difference
			ta_s3  <= 34'(pu_s2 + HALF36 + BIAS);
			tb_s3  <= 34'(pu_s2 - HALF36 + BIAS);
		end
	end

	// stripe coverage: periods and in-period offsets of both interval ends
	assign prod_a = 41'(ta_s3[33:17]) * 41'(MW);
	assign prod_b = 41'(tb_s3[33:17]) * 41'(MW);
	assign fa = {fha_s5, tal_s5};
	assign fb = {fhb_s5, tbl_s5};
	assign cov_raw = 32'(qd_s6) * 32'(RING_U) + 32'(ca_s6) - 32'(cb_s6);
	assign prod_c = 36'(cn_s8) * 36'(MRC);

	always_ff @(posedge clk) begin
		if (en) begin
			qa_s4  <= prod_a[40:27];
			qb_s4  <= prod_b[40:27];
			tah_s4 <= ta_s3[33:17];
			tbh_s4 <= tb_s3[33:17];
			tal_s4 <= ta_s3[16:0];
			tbl_s4 <= tb_s3[16:0];

			fha_s5 <= 10'(25'(tah_s4) - 25'(qa_s4) * 25'(SCREEN_WIDTH));
			fhb_s5 <= 10'(25'(tbh_s4) - 25'(qb_s4) * 25'(SCREEN_WIDTH));
			tal_s5 <= tal_s4;
			tbl_s5 <= tbl_s4;
			qd_s5  <= 4'(qa_s4 - qb_s4);

			ca_s6 <= (fa >= RING_U) ? 26'(fa - RING_U) : '0;
			cb_s6 <= (fb >= RING_U) ? 26'(fb - RING_U) : '0;
			qd_s6 <= qd_s5;

			if (cov_raw[31]) begin
				cov_s7 <= '0;
			end else if (cov_raw > 32'(UPX)) begin
				cov_s7 <= UPX;
			end else begin
				cov_s7 <= cov_raw[23:0];
			end

			cn_s8 <= 15'((33'(cov_s7) * 33'd510 + 33'(UPX)) >> 18);
			c0_s9 <= cov8_t'(prod_c >> 21);

			c0_dly_q[10] <= c0_s9;
			for (int k = 11; k <= 18; k++) c0_dly_q[k] <= c0_dly_q[k-1];
		end
	end

	rsm_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (d4_s3),
		.root     (sq_root),
		.rem      (sq_rem)
	);

	// rim coverage from the rounded distance
	always_comb begin
		rc_raw = $signed(RIM0) - $signed(21'(dq_s13));
		if (rc_raw[20]) begin
			rc_cl = '0;
		end else if (rc_raw > 21'sd256) begin
			rc_cl = 9'd256;
		end else begin
			rc_cl = rc_raw[8:0];
		end
	end

	assign prod_k = 45'(nk8_s14) * 45'(MKB);
	assign a_raw = 28'(dq_s15) * 28'(RING_COUNT)
		- ((28'(kb_s15[5:0]) * 28'(SCREEN_WIDTH)) << 7) + A_OFF;

	always_comb begin
		if (a_s16[27]) begin
			ac = '0;
		end else if (a_s16 > 28'(FULL)) begin
			ac = FULL;
		end else begin
			ac = a_s16[14:0];
		end
		af = odd_s16 ? FULL - ac : ac;
	end

	assign prod_w   = 36'(wn_s17) * 36'(MRC);
	assign prod_mix = 33'(p_s19) * 33'(DIV255_M);
	assign prod_fg  = 33'(fgp_s21) * 33'(DIV255_M);

	always_ff @(posedge clk) begin
		if (en) begin
			// round half up on the remainder
			dq_s13 <= 19'(sq_root) + 19'(sq_rem > REM_W'(sq_root));

			nk8_s14 <= 19'((27'(dq_s13) * 27'(2 * RING_COUNT) + KB_OFF) >> 8);
			m_s14   <= cov8_t'((17'(rc_cl) * 17'd255 + 17'd128) >> 8);
			dq_s14  <= dq_s13;

			kb_s15 <= 15'(prod_k >> 29);
			dq_s15 <= dq_s14;

			a_s16   <= a_raw;
			odd_s16 <= kb_s15[0];
			rng_s16 <= (kb_s15 >= 15'd1) && (kb_s15 <= KB_MAX);

			wn_s17  <= 15'((24'(af) * 24'd510 + 24'(FULL)) >> 9);
			rng_s17 <= rng_s16;

			// outside the inner boundaries the ring weight is full
			w_s18 <= rng_s17 ? cov8_t'(prod_w >> 21) : 8'd255;

			p_s19 <= 16'(16'(c0_dly_q[18]) * 16'(8'd255 - w_s18))
				+ 16'(16'(8'd255 - c0_dly_q[18]) * 16'(w_s18)) + 16'd127;
			mix_s20 <= cov8_t'(prod_mix >> DIV255_S);
			fgp_s21 <= 16'(16'(mix_s20) * 16'(m_dly_q[20])) + 16'd127;
			fg_s22  <= cov8_t'(prod_fg >> DIV255_S);

			m_dly_q[15] <= m_s14;
			for (int k = 16; k <= 20; k++) m_dly_q[k] <= m_dly_q[k-1];
		end
	end

	assign cov_valid   = vld_q[LAST];
	assign fg_coverage = fg_s22;
	assign frame_done  = eof_q[LAST];

endmodule

`default_nettype wire
